[sv/ipv6pp_pkg.sv]
// Package for the IPv6 prefix text parser.
// Holds the beat types of both channels and the status codes.
// No dependencies.
`default_nettype none
package ipv6pp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic [7:0]  length_bits;
  } result_beat_t;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusSlash    = 2'd1;
  localparam logic [1:0] StatusBadAddr  = 2'd2;
  localparam logic [1:0] StatusBadLen   = 2'd3;

  localparam logic [7:0] MaxLength      = 8'd128;

endpackage
`default_nettype wire

[sv/ipv6_prefix_text_parser.sv]
// The result beat appears in the cycle after the one that accepts the final character.
// Throughput: one character beat per cycle; the result register frees each cycle
// it is taken, and only a final character waits on a stalled result.
// Reset: rst (synchronous) clears the parse state and drops any pending result.
// IPv6 prefix text parser top level; depends on ipv6pp_pkg.
`default_nettype none
module ipv6_prefix_text_parser (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        req_valid,
  output logic                       req_stall,
  input  ipv6pp_pkg::char_beat_t     req_beat,
  output logic                       rsp_valid,
  input  wire                        rsp_stall,
  output ipv6pp_pkg::result_beat_t   rsp_beat
);
  import ipv6pp_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_COLON, PH_GAP, PH_HEX, PH_V4, PH_LEN, PH_EXTRA
  } phase_t;

  localparam logic [9:0] DecBad = 10'h3FF;

  function automatic logic [9:0] dec_add(input logic [9:0] acc, input logic [2:0] chars,
                                         input logic [3:0] d);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(d);
    if (acc == DecBad || chars >= 3'd3 || (chars >= 3'd1 && acc == 10'd0)) begin
      return DecBad;
    end
    if (v > 12'd255) begin
      return DecBad;
    end
    return v[9:0];
  endfunction

  logic [15:0] group_store [8];
  logic [3:0]  group_total;
  logic [3:0]  gap_index;
  logic        gap_seen;
  logic [15:0] hex_accum;
  logic [9:0]  dec_accum;
  logic [2:0]  field_chars;
  logic [23:0] tail_octets;
  logic [2:0]  octet_total;
  phase_t      parse_phase;
  logic [1:0]  error_code;
  logic [7:0]  length_accum;

  logic [15:0] group_store_next [8];
  logic [3:0]  group_total_next;
  logic [3:0]  gap_index_next;
  logic        gap_seen_next;
  logic [15:0] hex_accum_next;
  logic [9:0]  dec_accum_next;
  logic [2:0]  field_chars_next;
  logic [23:0] tail_octets_next;
  logic [2:0]  octet_total_next;
  phase_t      parse_phase_next;
  logic [1:0]  error_code_next;
  logic [7:0]  length_accum_next;
  result_beat_t result;

  logic accept;
  assign req_stall = rsp_valid && rsp_stall && req_beat.last_char;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    logic [7:0]   c;
    logic         is_dec;
    logic         is_hex;
    logic [3:0]   d;
    logic         do_hex;
    logic         skip;
    logic [15:0]  pv;
    logic [15:0]  exp_store [8];
    logic [3:0]   tail;
    logic [3:0]   src;
    logic [10:0]  lv;
    logic [1:0]   status;
    logic [127:0] addr;
    logic [127:0] mask;

    c      = req_beat.char_code;
    is_dec = c >= "0" && c <= "9";
    is_hex = is_dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    d      = is_dec ? c[3:0] : c[3:0] + 4'd9;
    do_hex = 1'b0;
    skip   = 1'b0;
    pv     = 16'd0;
    tail   = 4'd0;
    src    = 4'd0;
    lv     = 11'd0;
    addr   = '0;
    mask   = '0;
    for (int j = 0; j < 8; j++) begin
      exp_store[j] = 16'd0;
    end

    group_store_next  = group_store;
    group_total_next  = group_total;
    gap_index_next    = gap_index;
    gap_seen_next     = gap_seen;
    hex_accum_next    = hex_accum;
    dec_accum_next    = dec_accum;
    field_chars_next  = field_chars;
    tail_octets_next  = tail_octets;
    octet_total_next  = octet_total;
    parse_phase_next  = parse_phase;
    error_code_next   = error_code;
    length_accum_next = length_accum;

    if (parse_phase == PH_EXTRA) begin
    end else if (parse_phase == PH_LEN) begin
      if (c == "/") begin
        parse_phase_next = PH_EXTRA;
      end else if (error_code == StatusOk) begin
        lv = 11'(length_accum) * 11'd10 + 11'(c[3:0]);
        if (!is_dec || field_chars >= 3'd3 || (field_chars >= 3'd1 && length_accum == 8'd0)
            || lv > 11'(MaxLength)) begin
          error_code_next = StatusBadLen;
        end else begin
          length_accum_next = lv[7:0];
          field_chars_next  = field_chars + 3'd1;
        end
      end
    end else if (c == "/") begin
      if (error_code == StatusOk) begin
        unique case (parse_phase)
          PH_GAP: begin
          end
          PH_HEX: begin
            if (group_total_next < 4'd8) group_store_next[group_total_next[2:0]] = hex_accum;
            if (group_total_next < 4'd15) group_total_next = group_total_next + 4'd1;
            if (group_total_next > 4'd8 && error_code_next == StatusOk)
              error_code_next = StatusBadAddr;
          end
          PH_V4: begin
            if (field_chars == 3'd0 || octet_total != 3'd3) begin
              error_code_next = StatusBadAddr;
              skip = 1'b1;
            end else begin
              for (int k = 0; k < 2; k++) begin
                pv = (k == 0) ? tail_octets[23:8] : {tail_octets[7:0], dec_accum[7:0]};
                if (group_total_next < 4'd8) group_store_next[group_total_next[2:0]] = pv;
                if (group_total_next < 4'd15) group_total_next = group_total_next + 4'd1;
                if (group_total_next > 4'd8 && error_code_next == StatusOk)
                  error_code_next = StatusBadAddr;
              end
            end
          end
          default: begin
            error_code_next = StatusBadAddr;
            skip = 1'b1;
          end
        endcase
        if (!skip && error_code_next == StatusOk) begin
          if (!gap_seen) begin
            if (group_total_next != 4'd8) error_code_next = StatusBadAddr;
          end else if (group_total_next >= 4'd8 || gap_index > group_total_next) begin
            error_code_next = StatusBadAddr;
          end else begin
            tail = group_total_next - gap_index;
            for (int j = 0; j < 8; j++) begin
              src = 4'(j) + group_total_next - 4'd8;
              if (4'(j) >= 4'd8 - tail) begin
                exp_store[j] = group_store_next[src[2:0]];
              end else if (4'(j) >= gap_index) begin
                exp_store[j] = 16'd0;
              end else begin
                exp_store[j] = group_store_next[j];
              end
            end
            group_store_next = exp_store;
          end
        end
      end
      parse_phase_next = PH_LEN;
      field_chars_next = 3'd0;
    end else if (error_code == StatusOk) begin
      if (c == "%") begin
        error_code_next = StatusBadAddr;
      end else begin
        unique case (parse_phase)
          PH_START: begin
            if (c == ":") parse_phase_next = PH_COLON;
            else do_hex = 1'b1;
          end
          PH_COLON: begin
            if (c == ":") begin
              if (gap_seen) begin
                error_code_next = StatusBadAddr;
              end else begin
                gap_seen_next    = 1'b1;
                gap_index_next   = group_total;
                parse_phase_next = PH_GAP;
              end
            end else if (group_total == 4'd0) begin
              error_code_next = StatusBadAddr;
            end else begin
              do_hex = 1'b1;
            end
          end
          PH_GAP: begin
            if (c == ":") parse_phase_next = PH_COLON;
            else do_hex = 1'b1;
          end
          PH_HEX: begin
            if (c == ":") begin
              if (group_total < 4'd8) group_store_next[group_total[2:0]] = hex_accum;
              if (group_total < 4'd15) group_total_next = group_total + 4'd1;
              if (group_total_next > 4'd8) error_code_next = StatusBadAddr;
              parse_phase_next = PH_COLON;
            end else begin
              do_hex = 1'b1;
            end
          end
          default: begin
            if (c == ".") begin
              if (field_chars == 3'd0 || octet_total >= 3'd3) begin
                error_code_next = StatusBadAddr;
              end else begin
                tail_octets_next = {tail_octets[15:0], dec_accum[7:0]};
                octet_total_next = octet_total + 3'd1;
                dec_accum_next   = 10'd0;
                field_chars_next = 3'd0;
              end
            end else if (!is_dec) begin
              error_code_next = StatusBadAddr;
            end else begin
              dec_accum_next = dec_add(dec_accum, field_chars, d);
              if (dec_accum_next == DecBad) begin
                error_code_next = StatusBadAddr;
              end else begin
                field_chars_next = field_chars + 3'd1;
              end
            end
          end
        endcase
        if (do_hex) begin
          if (parse_phase != PH_HEX) begin
            parse_phase_next = PH_HEX;
            hex_accum_next   = 16'd0;
            dec_accum_next   = 10'd0;
            field_chars_next = 3'd0;
          end
          if (c == ".") begin
            if (field_chars_next == 3'd0 || dec_accum_next == DecBad) begin
              error_code_next = StatusBadAddr;
            end else begin
              tail_octets_next = 24'(dec_accum_next);
              octet_total_next = 3'd1;
              dec_accum_next   = 10'd0;
              field_chars_next = 3'd0;
              parse_phase_next = PH_V4;
            end
          end else if (!is_hex || field_chars_next >= 3'd4) begin
            error_code_next = StatusBadAddr;
          end else begin
            hex_accum_next   = {hex_accum_next[11:0], d};
            dec_accum_next   = is_dec ? dec_add(dec_accum_next, field_chars_next, d) : DecBad;
            field_chars_next = field_chars_next + 3'd1;
          end
        end
      end
    end

    if (parse_phase_next != PH_LEN) begin
      status = StatusSlash;
    end else if (error_code_next == StatusOk && field_chars_next == 3'd0) begin
      status = StatusBadLen;
    end else begin
      status = error_code_next;
    end

    result = '0;
    result.status = status;
    if (status == StatusOk) begin
      for (int j = 0; j < 8; j++) begin
        addr[127 - 16*j -: 16] = group_store_next[j];
      end
      mask = ~({128{1'b1}} >> length_accum_next);
      addr = addr & mask;
      result.addr_upper  = addr[127:64];
      result.addr_lower  = addr[63:0];
      result.length_bits = length_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && req_beat.last_char)) begin
      for (int j = 0; j < 8; j++) begin
        group_store[j] <= 16'd0;
      end
      group_total  <= 4'd0;
      gap_index    <= 4'd0;
      gap_seen     <= 1'b0;
      hex_accum    <= 16'd0;
      dec_accum    <= 10'd0;
      field_chars  <= 3'd0;
      tail_octets  <= 24'd0;
      octet_total  <= 3'd0;
      parse_phase  <= PH_START;
      error_code   <= StatusOk;
      length_accum <= 8'd0;
    end else if (accept) begin
      group_store  <= group_store_next;
      group_total  <= group_total_next;
      gap_index    <= gap_index_next;
      gap_seen     <= gap_seen_next;
      hex_accum    <= hex_accum_next;
      dec_accum    <= dec_accum_next;
      field_chars  <= field_chars_next;
      tail_octets  <= tail_octets_next;
      octet_total  <= octet_total_next;
      parse_phase  <= parse_phase_next;
      error_code   <= error_code_next;
      length_accum <= length_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && req_beat.last_char) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_beat.last_char) begin
      rsp_beat <= result;
    end
  end

endmodule
`default_nettype wire

[sv/ipv6pp_checker.sv]
// Port-level checker for the IPv6 prefix text parser, bound to the top level.
// Depends on ipv6pp_pkg and ipv6_prefix_text_parser.
`default_nettype none
module ipv6pp_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        req_valid,
  input wire                        req_stall,
  input ipv6pp_pkg::char_beat_t     req_beat,
  input wire                        rsp_valid,
  input wire                        rsp_stall,
  input ipv6pp_pkg::result_beat_t   rsp_beat
);
  import ipv6pp_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_beat.status != StatusOk |->
      rsp_beat.addr_upper == 64'd0 && rsp_beat.addr_lower == 64'd0 &&
      rsp_beat.length_bits == 8'd0)
    else $error("error result carries nonzero payload");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_beat.length_bits <= MaxLength)
    else $error("prefix length out of range");

  a_host_mask: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_beat.length_bits <= 8'd64 |-> rsp_beat.addr_lower == 64'd0)
    else $error("host bits not cleared");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !(req_valid && !req_stall && req_beat.last_char) |=> !rsp_valid)
    else $error("result beat without a final character");

endmodule

bind ipv6_prefix_text_parser ipv6pp_checker u_ipv6pp_checker (.*);
`default_nettype wire
